### rtl/core/lea_pkg.sv
package lea_pkg;

  typedef logic [3:0][31:0] state_word_t;  // x0..x3 of the cipher state
  typedef logic [5:0][31:0] round_key_t;   // six key words of one round

  localparam int unsigned MAX_ROUNDS = 32;

  // key_length codes
  localparam logic [1:0] KEY_LEN_128 = 2'd0;
  localparam logic [1:0] KEY_LEN_192 = 2'd1;
  localparam logic [1:0] KEY_LEN_256 = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_KEY_LENGTH = 3'd0;
  localparam logic [2:0] CFG_KEY_0_7    = 3'd1;
  localparam logic [2:0] CFG_KEY_8_15   = 3'd2;
  localparam logic [2:0] CFG_KEY_16_23  = 3'd3;
  localparam logic [2:0] CFG_KEY_24_31  = 3'd4;

  localparam logic [5:0] ROUNDS_128 = 6'd24;
  localparam logic [5:0] ROUNDS_192 = 6'd28;
  localparam logic [5:0] ROUNDS_256 = 6'd32;

  localparam logic [31:0] DELTA [8] = '{
    32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec,
    32'h715ea49e, 32'hc785da0a, 32'he04ef22a, 32'he5c40957
  };

  localparam logic [4:0] KS_SHIFT [6] = '{5'd1, 5'd3, 5'd6, 5'd11, 5'd13, 5'd17};

  // key schedule sequencer, one-hot
  typedef enum logic [2:0] {
    KS_LOAD = 3'b001,
    KS_RUN  = 3'b010,
    KS_DONE = 3'b100
  } ks_state_t;

  function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} >> n;
    return w[31:0];
  endfunction

  function automatic state_word_t enc_round(input state_word_t x, input round_key_t k);
    state_word_t y;
    y[0] = rol32((x[0] ^ k[0]) + (x[1] ^ k[1]), 5'd9);
    y[1] = ror32((x[1] ^ k[2]) + (x[2] ^ k[3]), 5'd5);
    y[2] = ror32((x[2] ^ k[4]) + (x[3] ^ k[5]), 5'd3);
    y[3] = x[0];
    return y;
  endfunction

  function automatic state_word_t dec_round(input state_word_t x, input round_key_t k);
    state_word_t y;
    y[0] = x[3];
    y[1] = (ror32(x[0], 5'd9) - (y[0] ^ k[0])) ^ k[1];
    y[2] = (rol32(x[1], 5'd5) - (y[1] ^ k[2])) ^ k[3];
    y[3] = (rol32(x[2], 5'd3) - (y[2] ^ k[4])) ^ k[5];
    return y;
  endfunction

endpackage

### rtl/core/lea_block_cipher_top.sv
// LEA block cipher, ECB core with 128/192/256-bit keys (24/28/32 rounds).
// Each input word carries one 128-bit block and a mode flag (tuser: 0 encrypt,
// 1 decrypt); each output word carries the transformed block, in input order.
// The datapath is a 32-stage round pipeline plus an input register, one round
// per stage: one block enters per cycle unless the output is stalled. Shorter
// keys pass through the unused stages (at the tail for encrypt, at the head for
// decrypt). The whole pipeline freezes while the output is stalled. Round keys
// are expanded once by a sequencer after reset and after every configuration
// write: one round per cycle, and the input is held off until every round key
// of the selected key length is ready.
module lea_block_cipher_top (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // block_low [63:0], block_high [127:64]
  input  logic         s_tuser,   // mode
  // output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // out_low [63:0], out_high [127:64]
  // configuration
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_wdata
);

  // ---------------------------------------------------------------- config
  logic [1:0]  key_len;
  logic [63:0] key_reg [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_len <= lea_pkg::KEY_LEN_128;
      for (int k = 0; k < 4; k++) key_reg[k] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lea_pkg::CFG_KEY_LENGTH: key_len    <= cfg_wdata[1:0];
        lea_pkg::CFG_KEY_0_7:    key_reg[0] <= cfg_wdata;
        lea_pkg::CFG_KEY_8_15:   key_reg[1] <= cfg_wdata;
        lea_pkg::CFG_KEY_16_23:  key_reg[2] <= cfg_wdata;
        lea_pkg::CFG_KEY_24_31:  key_reg[3] <= cfg_wdata;
        default: ;  // unknown index is ignored
      endcase
    end
  end

  logic       is128, is192, is256;
  logic [5:0] num_rounds;

  // key length three counts as 256-bit
  always_comb begin
    is128 = 1'b0;
    is192 = 1'b0;
    is256 = 1'b0;
    unique case (key_len)
      lea_pkg::KEY_LEN_128: begin
        is128      = 1'b1;
        num_rounds = lea_pkg::ROUNDS_128;
      end
      lea_pkg::KEY_LEN_192: begin
        is192      = 1'b1;
        num_rounds = lea_pkg::ROUNDS_192;
      end
      default: begin
        is256      = 1'b1;
        num_rounds = lea_pkg::ROUNDS_256;
      end
    endcase
  end

  // ---------------------------------------------------------- key schedule
  lea_pkg::ks_state_t ks_state;
  logic [31:0]        ks_t [8];     // running key state words
  logic [4:0]         ks_cnt;       // round being expanded
  logic [2:0]         ks_base;      // 6*round mod 8, word offset for 256-bit keys
  logic [2:0]         ks_mod6;      // round mod 6, delta pick for 192-bit keys
  lea_pkg::round_key_t rk [lea_pkg::MAX_ROUNDS];

  logic [31:0]        ks_delta;
  logic [2:0]         ks_idx [6];
  logic [31:0]        ks_val [6];
  lea_pkg::round_key_t ks_rk;

  always_comb begin
    priority if (is128)      ks_delta = lea_pkg::DELTA[{1'b0, ks_cnt[1:0]}];
    else if (is192)          ks_delta = lea_pkg::DELTA[ks_mod6];
    else                     ks_delta = lea_pkg::DELTA[ks_cnt[2:0]];
    for (int j = 0; j < 6; j++) begin
      ks_idx[j] = is256 ? 3'(ks_base + 3'(j)) : 3'(j);
      ks_val[j] = lea_pkg::rol32(
          ks_t[ks_idx[j]] + lea_pkg::rol32(ks_delta, 5'(ks_cnt + 5'(j))),
          lea_pkg::KS_SHIFT[j]);
    end
    // 128-bit keys reuse the second word three times
    if (is128) ks_rk = {ks_val[1], ks_val[3], ks_val[1], ks_val[2], ks_val[1], ks_val[0]};
    else       ks_rk = {ks_val[5], ks_val[4], ks_val[3], ks_val[2], ks_val[1], ks_val[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ks_state <= lea_pkg::KS_LOAD;
    end else if (cfg_we) begin
      ks_state <= lea_pkg::KS_LOAD;  // any write restarts the expansion
    end else begin
      unique case (ks_state)
        lea_pkg::KS_LOAD: ks_state <= lea_pkg::KS_RUN;
        lea_pkg::KS_RUN: begin
          if ({1'b0, ks_cnt} == 6'(num_rounds - 6'd1)) ks_state <= lea_pkg::KS_DONE;
        end
        lea_pkg::KS_DONE: ;
        default: ks_state <= lea_pkg::KS_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ks_state == lea_pkg::KS_LOAD) begin
      for (int k = 0; k < 4; k++) begin
        ks_t[2*k]   <= key_reg[k][31:0];
        ks_t[2*k+1] <= key_reg[k][63:32];
      end
      ks_cnt  <= '0;
      ks_base <= '0;
      ks_mod6 <= '0;
    end else if (ks_state == lea_pkg::KS_RUN) begin
      for (int j = 0; j < 6; j++) begin
        if (j < 4 || !is128) ks_t[ks_idx[j]] <= ks_val[j];
      end
      rk[ks_cnt] <= ks_rk;
      ks_cnt     <= ks_cnt + 5'd1;
      ks_base    <= ks_base + 3'd6;
      ks_mod6    <= (ks_mod6 == 3'd5) ? 3'd0 : ks_mod6 + 3'd1;
    end
  end

  // -------------------------------------------------------- round pipeline
  logic                 adv;
  logic [32:0]          stg_valid;
  logic [32:0]          stg_mode;
  lea_pkg::state_word_t stg_data [33];

  // whole pipeline moves unless the output word is stuck
  assign adv      = !stg_valid[32] || m_tready;
  assign s_tready = adv && (ks_state == lea_pkg::KS_DONE) && !cfg_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid[0] <= 1'b0;
    end else if (adv) begin
      stg_valid[0] <= s_tvalid && s_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_mode[0] <= s_tuser;
      stg_data[0] <= s_tdata;
    end
  end

  for (genvar s = 0; s < 32; s++) begin : g_round
    lea_pkg::round_key_t  key;
    lea_pkg::state_word_t nxt;
    logic                 act;

    // encrypt runs rounds at the head, decrypt at the tail in reverse
    always_comb begin
      key = stg_mode[s] ? rk[31 - s] : rk[s];
      act = stg_mode[s] ? (6'(s) >= 6'(6'd32 - num_rounds)) : (6'(s) < num_rounds);
      if (!act)             nxt = stg_data[s];
      else if (stg_mode[s]) nxt = lea_pkg::dec_round(stg_data[s], key);
      else                  nxt = lea_pkg::enc_round(stg_data[s], key);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[s+1] <= 1'b0;
      end else if (adv) begin
        stg_valid[s+1] <= stg_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg_mode[s+1] <= stg_mode[s];
        stg_data[s+1] <= nxt;
      end
    end
  end

  assign m_tvalid = stg_valid[32];
  assign m_tdata  = stg_data[32];

  // ------------------------------------------------------------ assertions
  a_no_input_while_expanding: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> ks_state == lea_pkg::KS_DONE)
    else $error("input accepted before round keys are ready");

  a_load_then_run: assert property (@(posedge clk) disable iff (rst)
    (ks_state == lea_pkg::KS_LOAD && !cfg_we) |=> ks_state == lea_pkg::KS_RUN)
    else $error("key schedule did not start after load");

  a_run_in_range: assert property (@(posedge clk) disable iff (rst)
    ks_state == lea_pkg::KS_RUN |-> {1'b0, ks_cnt} < num_rounds)
    else $error("key schedule ran past the round count");

  a_accept_enters_pipe: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> stg_valid[0])
    else $error("accepted word lost at pipeline entry");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(stg_valid))
    else $error("pipeline moved during output stall");

endmodule
